@@ hw/rtl/sobel_gradient_magnitude_unit_macros.svh @@
// assertion helpers shared by the edge magnitude rtl
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sgm_pkg.sv @@
package sgm_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int MAG_BITS   = 11;

  // |gradient| <= 4 * pixel max, plus sign
  localparam int GRAD_BITS = PIXEL_BITS + 3;
  localparam int ABS_BITS  = PIXEL_BITS + 2;
  localparam int SQ_BITS   = 2 * ABS_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;

  // two root bits per pipeline stage
  localparam int SQRT_STAGES = (SUM_BITS + 3) / 4;
  localparam int RAD_BITS    = 4 * SQRT_STAGES;
  localparam int ROOT_BITS   = 2 * SQRT_STAGES;
  localparam int REM_BITS    = ROOT_BITS + 2;

  localparam int WIDE_BITS = (ROOT_BITS > MAG_BITS) ? ROOT_BITS : MAG_BITS;
  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  typedef logic [PIXEL_BITS-1:0]       pixel_t;
  typedef logic signed [GRAD_BITS-1:0] grad_t;
  typedef logic [ABS_BITS-1:0]         grad_abs_t;
  typedef logic [SQ_BITS-1:0]          square_t;
  typedef logic [SUM_BITS-1:0]         sum_t;
  typedef logic [RAD_BITS-1:0]         radicand_t;
  typedef logic [MAG_BITS-1:0]         mag_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_acc_t;

  function automatic grad_t pixel_ext(pixel_t p);
    return grad_t'({{(GRAD_BITS - PIXEL_BITS){1'b0}}, p});
  endfunction

  function automatic grad_abs_t grad_abs(grad_t g);
    grad_t a;
    a = g[GRAD_BITS-1] ? -g : g;
    return a[ABS_BITS-1:0];
  endfunction

  // one restoring square-root digit: bring down a bit pair, try root*4+1
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [REM_BITS-1:0] trial;
    logic [REM_BITS-1:0] test;
    sqrt_acc_t           nxt;
    trial = {acc.rem[REM_BITS-3:0], pair};
    test  = {acc.root, 2'b01};
    if (trial >= test) begin
      nxt.rem  = trial - test;
      nxt.root = {acc.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      nxt.rem  = trial;
      nxt.root = {acc.root[ROOT_BITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

@@ hw/rtl/sobel_gradient_magnitude_unit.sv @@
// 3x3 sobel edge magnitude. Each transfer on the input carries one window of
// nine unsigned pixels; the unit forms the vertical gradient (columns left
// minus right, weights 1-2-1) and the horizontal gradient (rows top minus
// bottom, weights 1-2-1), and returns floor(sqrt(gv^2 + gh^2)) as an 11-bit
// magnitude, 0..1442 for 8-bit pixels (saturating at the field maximum for
// wider pixels). The center pixel has no weight and is ignored. One window
// is taken every clock while in_stall is low. There are ten register stages
// (3 arithmetic stages, 6 square-root stages producing two root bits each,
// one output register), the first loading at the input transfer and the
// last driving out_valid and edge_magnitude. Output stall backs up stage by
// stage, so bubbles are squeezed out and in_stall only rises once every
// stage holds a window.
// No state survives between windows; reset only clears the valid bits.
module sobel_gradient_magnitude_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sgm_pkg::pixel_t       pixel_top_left,
  input  sgm_pkg::pixel_t       pixel_top_mid,
  input  sgm_pkg::pixel_t       pixel_top_right,
  input  sgm_pkg::pixel_t       pixel_mid_left,
  input  sgm_pkg::pixel_t       pixel_center,
  input  sgm_pkg::pixel_t       pixel_mid_right,
  input  sgm_pkg::pixel_t       pixel_bot_left,
  input  sgm_pkg::pixel_t       pixel_bot_mid,
  input  sgm_pkg::pixel_t       pixel_bot_right,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgm_pkg::mag_t         edge_magnitude
);
  import sgm_pkg::*;

  // stage map: gradients, squares, sum, square-root digits, output
  localparam int GRAD_ST   = 0;
  localparam int SQUARE_ST = 1;
  localparam int SUM_ST    = 2;
  localparam int SQRT_BASE = 3;
  localparam int OUT_ST    = SQRT_BASE + SQRT_STAGES;
  localparam int NUM_ST    = OUT_ST + 1;

  logic [NUM_ST-1:0] vld;
  logic [NUM_ST:0]   ready;
  logic [NUM_ST-1:0] vld_in;

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    ready[NUM_ST] = !out_stall;
    for (int i = NUM_ST - 1; i >= 0; i--) begin
      ready[i]  = !vld[i] || ready[i+1];
      vld_in[i] = (i == 0) ? in_valid : vld[(i == 0) ? 0 : i - 1];
    end
  end

  assign in_stall  = !ready[GRAD_ST];
  assign out_valid = vld[OUT_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_ST; i++) begin
        if (ready[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // stage 0: the two gradients, adds only
  grad_t grad_v;
  grad_t grad_h;

  always_ff @(posedge clk) begin
    if (ready[GRAD_ST]) begin
      grad_v <= pixel_ext(pixel_top_left) - pixel_ext(pixel_top_right)
              + (pixel_ext(pixel_mid_left) <<< 1) - (pixel_ext(pixel_mid_right) <<< 1)
              + pixel_ext(pixel_bot_left) - pixel_ext(pixel_bot_right);
      grad_h <= pixel_ext(pixel_top_left) + (pixel_ext(pixel_top_mid) <<< 1)
              + pixel_ext(pixel_top_right) - pixel_ext(pixel_bot_left)
              - (pixel_ext(pixel_bot_mid) <<< 1) - pixel_ext(pixel_bot_right);
    end
  end

  // stage 1: magnitude and square of each gradient, one small multiplier each
  grad_abs_t abs_v;
  grad_abs_t abs_h;
  square_t   sq_v;
  square_t   sq_h;

  assign abs_v = grad_abs(grad_v);
  assign abs_h = grad_abs(grad_h);

  always_ff @(posedge clk) begin
    if (ready[SQUARE_ST]) begin
      sq_v <= square_t'(abs_v) * square_t'(abs_v);
      sq_h <= square_t'(abs_h) * square_t'(abs_h);
    end
  end

  // stage 2: sum of squares
  sum_t sum_sq;

  always_ff @(posedge clk) begin
    if (ready[SUM_ST]) begin
      sum_sq <= SUM_BITS'(sq_v) + SUM_BITS'(sq_h);
    end
  end

  // square-root stages: each brings down two bit pairs of the radicand,
  // msb first, and settles two root bits
  radicand_t rad_q  [SQRT_STAGES];
  sqrt_acc_t acc_q  [SQRT_STAGES];
  radicand_t rad_nx [SQRT_STAGES];
  sqrt_acc_t acc_nx [SQRT_STAGES];
  radicand_t rad_src[SQRT_STAGES];
  sqrt_acc_t acc_src[SQRT_STAGES];
  sqrt_acc_t acc_mid[SQRT_STAGES];

  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rad_src[k] = RAD_BITS'(sum_sq);
        acc_src[k] = '0;
      end else begin
        rad_src[k] = rad_q[(k == 0) ? 0 : k - 1];
        acc_src[k] = acc_q[(k == 0) ? 0 : k - 1];
      end
      acc_mid[k] = sqrt_step(acc_src[k], rad_src[k][RAD_BITS-1 -: 2]);
      acc_nx[k]  = sqrt_step(acc_mid[k], rad_src[k][RAD_BITS-3 -: 2]);
      rad_nx[k]  = rad_src[k] << 4;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (ready[SQRT_BASE + k]) begin
        rad_q[k] <= rad_nx[k];
        acc_q[k] <= acc_nx[k];
      end
    end
  end

  // output register with saturation to the field width
  logic [WIDE_BITS-1:0] root_wide;
  mag_t                 mag_next;

  assign root_wide = WIDE_BITS'(acc_q[SQRT_STAGES-1].root);
  assign mag_next  = (root_wide > WIDE_BITS'(MAG_MAX)) ? MAG_MAX : MAG_BITS'(root_wide);

  always_ff @(posedge clk) begin
    if (ready[OUT_ST]) begin
      edge_magnitude <= mag_next;
    end
  end

`include "sobel_gradient_magnitude_unit_macros.svh"

  `SGM_ASSERT_NOW(a_stall_only_when_full, in_stall, &vld, "input stalled with a free stage")
  `SGM_ASSERT_NOW(a_free_flow, !out_stall, !in_stall, "input stalled while output drains")
  `SGM_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld[GRAD_ST], "accepted window lost")
  `SGM_ASSERT_NOW(a_root_remainder, vld[OUT_ST - 1],
    acc_q[SQRT_STAGES-1].rem <= {1'b0, acc_q[SQRT_STAGES-1].root, 1'b0},
    "square root remainder exceeds twice the root")

endmodule
